// File: rtl/strip_hit_clusterer_macros.svh
// Assertion helpers shared by the clusterer RTL.
`ifndef STRIP_HIT_CLUSTERER_MACROS_SVH
`define STRIP_HIT_CLUSTERER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/shc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shc_pkg;

  localparam int SEG_W = 10;
  localparam int POS_W = 20;
  localparam int ID_W = 10;
  localparam int CNT_W = 11;
  localparam int SUM_W = 30;
  localparam int LAT_W = 20;
  localparam int OFS_W = 12;
  localparam int REM_W = CNT_W + 1;
  localparam int SEGMENT_COUNT = 1024;
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int IN_W = 32;
  localparam int OUT_W = 72;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v < CNT_W'(SEGMENT_COUNT)) ? v + CNT_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/strip_hit_clusterer.sv
`timescale 1ns / 1ps
`default_nettype none

// Groups the hits of one detector layer, sent in ascending segment order, into clusters of
// neighboring segments and emits one record per closed cluster with its id, hit count,
// depth size, lateral size (1/256 units, plus even_offset when the depth size is even) and
// the mean position truncated toward zero. A hit that only joins or opens a cluster is taken
// without a stall. A hit that closes a cluster is followed by the shared restoring divider,
// one quotient bit per cycle over the 30-bit position sum, and by the load of the output
// register, and only then is the next hit taken. A last hit that closes no cluster first
// passes through S_SNAP to capture its own cluster. A hit that closes a cluster and ends
// the layer emits two clusters. A finished cluster that waits for a full output register
// holds off the next hit further. The output register holds a finished cluster while the
// block already takes the next hit.
module strip_hit_clusterer (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [shc_pkg::OFS_W-1:0] cfg_wdata,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // Fields from bit 0: segment[9:0], position[29:10], zero fill.
  input  wire logic [shc_pkg::IN_W-1:0]  s_tdata,
  input  wire logic                      s_tlast,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // Fields from bit 0: cluster_id[9:0], hit_count[20:10], depth_size[31:21],
  // lateral_size[51:32], mean_position[71:52].
  output logic [shc_pkg::OUT_W-1:0]      m_tdata,
  output logic                           m_tlast
);

  typedef enum logic [1:0] {S_IDLE, S_SNAP, S_DIV, S_OUT} state_t;

  state_t state;

  logic [shc_pkg::OFS_W-1:0] even_offset;

  logic                      open_flag;
  logic [shc_pkg::SEG_W-1:0] prev_segment;
  logic [shc_pkg::SEG_W-1:0] prev2_segment;
  logic                      prev2_valid;
  logic [shc_pkg::CNT_W-1:0] count_reg;
  logic [shc_pkg::CNT_W-1:0] depth_count;
  logic [shc_pkg::CNT_W-1:0] lateral_count;
  logic [shc_pkg::SUM_W-1:0] position_sum;
  logic [shc_pkg::ID_W-1:0]  next_cluster_id;

  logic [shc_pkg::ID_W-1:0]  e_id;
  logic [shc_pkg::CNT_W-1:0] e_count;
  logic [shc_pkg::CNT_W-1:0] e_depth;
  logic [shc_pkg::LAT_W-1:0] e_lat;
  logic                      e_neg;
  logic                      e_lor;
  logic                      pend_last;

  logic [shc_pkg::SUM_W-1:0]     dq;
  logic [shc_pkg::REM_W-1:0]     rem;
  logic [shc_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [shc_pkg::SEG_W-1:0] seg_in;
  logic [shc_pkg::POS_W-1:0] pos_in;
  logic [shc_pkg::CNT_W-1:0] step;
  logic [shc_pkg::CNT_W-1:0] step2;
  logic                      is_join;
  logic                      accept;
  logic [shc_pkg::LAT_W-1:0] lat_now;
  logic [shc_pkg::SUM_W-1:0] abs_sum;
  logic [shc_pkg::REM_W-1:0] rem_sh;
  logic                      rem_ge;
  logic [shc_pkg::REM_W-1:0] rem_next;
  logic [shc_pkg::SUM_W-1:0] dq_next;
  logic [shc_pkg::POS_W-1:0] mean_out;
  logic                      out_load;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign seg_in   = s_tdata[shc_pkg::SEG_W-1:0];
  assign pos_in   = s_tdata[shc_pkg::SEG_W +: shc_pkg::POS_W];

  assign step    = {1'b0, seg_in} - {1'b0, prev_segment};
  assign step2   = {1'b0, seg_in} - {1'b0, prev2_segment};
  assign is_join = open_flag &&
                   (step == shc_pkg::CNT_W'(1) || step == shc_pkg::CNT_W'(2));

  assign lat_now = {1'b0, lateral_count, 8'b0} +
                   (depth_count[0] ? '0
                    : {{(shc_pkg::LAT_W-shc_pkg::OFS_W){even_offset[shc_pkg::OFS_W-1]}},
                       even_offset});
  assign abs_sum = position_sum[shc_pkg::SUM_W-1] ? (~position_sum + shc_pkg::SUM_W'(1))
                                                  : position_sum;

  assign rem_sh   = {rem[shc_pkg::REM_W-2:0], dq[shc_pkg::SUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, e_count};
  assign rem_next = rem_ge ? rem_sh - {1'b0, e_count} : rem_sh;
  assign dq_next  = {dq[shc_pkg::SUM_W-2:0], rem_ge};

  assign mean_out = e_neg ? (~dq[shc_pkg::POS_W-1:0] + shc_pkg::POS_W'(1))
                          : dq[shc_pkg::POS_W-1:0];
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      even_offset     <= '0;
      open_flag       <= 1'b0;
      prev_segment    <= '0;
      prev2_segment   <= '0;
      prev2_valid     <= 1'b0;
      count_reg       <= '0;
      depth_count     <= shc_pkg::CNT_W'(1);
      lateral_count   <= shc_pkg::CNT_W'(1);
      position_sum    <= '0;
      next_cluster_id <= '0;
      pend_last       <= 1'b0;
      div_cnt         <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        even_offset <= cfg_wdata;
      end
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (open_flag && !is_join) begin
              e_id            <= next_cluster_id;
              e_count         <= count_reg;
              e_depth         <= depth_count;
              e_lat           <= lat_now;
              e_neg           <= position_sum[shc_pkg::SUM_W-1];
              e_lor           <= !s_tlast;
              dq              <= abs_sum;
              rem             <= '0;
              div_cnt         <= '0;
              next_cluster_id <= next_cluster_id + shc_pkg::ID_W'(1);
              pend_last       <= s_tlast;
              state           <= S_DIV;
            end else if (s_tlast) begin
              pend_last <= 1'b1;
              state     <= S_SNAP;
            end
            if (is_join) begin
              count_reg <= shc_pkg::sat_inc(count_reg);
              if (step == shc_pkg::CNT_W'(1)) begin
                depth_count <= shc_pkg::sat_inc(depth_count);
              end
              if (step == shc_pkg::CNT_W'(2) ||
                  (prev2_valid && step2 == shc_pkg::CNT_W'(2))) begin
                lateral_count <= shc_pkg::sat_inc(lateral_count);
              end
              position_sum  <= position_sum +
                               {{(shc_pkg::SUM_W-shc_pkg::POS_W){pos_in[shc_pkg::POS_W-1]}},
                                pos_in};
              prev2_segment <= prev_segment;
              prev2_valid   <= 1'b1;
              prev_segment  <= seg_in;
            end else begin
              open_flag     <= 1'b1;
              prev_segment  <= seg_in;
              prev2_segment <= '0;
              prev2_valid   <= 1'b0;
              count_reg     <= shc_pkg::CNT_W'(1);
              depth_count   <= shc_pkg::CNT_W'(1);
              lateral_count <= shc_pkg::CNT_W'(1);
              position_sum  <= {{(shc_pkg::SUM_W-shc_pkg::POS_W){pos_in[shc_pkg::POS_W-1]}},
                                pos_in};
            end
          end
        end
        S_SNAP: begin
          e_id            <= next_cluster_id;
          e_count         <= count_reg;
          e_depth         <= depth_count;
          e_lat           <= lat_now;
          e_neg           <= position_sum[shc_pkg::SUM_W-1];
          e_lor           <= 1'b1;
          dq              <= abs_sum;
          rem             <= '0;
          div_cnt         <= '0;
          pend_last       <= 1'b0;
          open_flag       <= 1'b0;
          prev_segment    <= '0;
          prev2_segment   <= '0;
          prev2_valid     <= 1'b0;
          count_reg       <= '0;
          depth_count     <= shc_pkg::CNT_W'(1);
          lateral_count   <= shc_pkg::CNT_W'(1);
          position_sum    <= '0;
          next_cluster_id <= '0;
          state           <= S_DIV;
        end
        S_DIV: begin
          dq      <= dq_next;
          rem     <= rem_next;
          div_cnt <= div_cnt + shc_pkg::DIV_CNT_W'(1);
          if (div_cnt == shc_pkg::DIV_CNT_W'(shc_pkg::DIV_STEPS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {mean_out, e_lat, e_depth, e_count, e_id};
            m_tlast  <= e_lor;
            state    <= pend_last ? S_SNAP : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "strip_hit_clusterer_macros.svh"

  `SHC_ASSERT_NEXT(a_last_blocks_input, clk, rst, accept && s_tlast, !s_tready, "last hit did not start an emit")
  `SHC_ASSERT_SAME(a_div_nonzero, clk, rst, state == S_DIV, e_count != '0, "divide by zero count")
  `SHC_ASSERT_SAME(a_first_of_two, clk, rst, out_load && !e_lor, pend_last, "second cluster lost")
  `SHC_ASSERT_SAME(a_div_range, clk, rst, state == S_DIV, div_cnt < shc_pkg::DIV_CNT_W'(shc_pkg::DIV_STEPS), "divider step out of range")

endmodule

`default_nettype wire

// File: tb/strip_hit_clusterer_checker.sv
`timescale 1ns / 1ps

module strip_hit_clusterer_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [shc_pkg::OFS_W-1:0]        cfg_wdata,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [shc_pkg::IN_W-1:0]         s_tdata,
  input  logic                             s_tlast,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [shc_pkg::OUT_W-1:0]        m_tdata,
  input  logic                             m_tlast,
  output int                               mismatches,
  output int                               outstanding,
  output int                               clusters_checked
);
  import shc_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] depth;
    logic [LAT_W-1:0] lateral;
    logic [POS_W-1:0] mean;
    logic             last_of_run;
  } cluster_t;

  logic signed [OFS_W-1:0] even_offset;
  bit                      cl_open;
  logic [SEG_W-1:0]        last_seg;
  logic [SEG_W-1:0]        older_seg;
  bit                      older_ok;
  logic [CNT_W-1:0]        n_hits;
  logic [CNT_W-1:0]        n_depth;
  logic [CNT_W-1:0]        n_lateral;
  longint                  sum_pos;
  logic [ID_W-1:0]         id_next;
  cluster_t                expected_clusters[$];
  int                      err_cnt = 0;
  int                      done_cnt = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [ID_W-1:0] id,
                             input longint got, input longint want);
    if (got != want) begin
      report_mismatch($sformatf("cluster %0d %s: got %0d, expected %0d", id, name, got, want));
    end
  endtask

  function automatic void open_cluster(input logic [SEG_W-1:0] seg, input longint pos);
    cl_open = 1'b1;
    last_seg = seg;
    older_seg = '0;
    older_ok = 1'b0;
    n_hits = CNT_W'(1);
    n_depth = CNT_W'(1);
    n_lateral = CNT_W'(1);
    sum_pos = pos;
  endfunction

  function automatic void emit_cluster(input bit last_of_run);
    cluster_t c;
    longint lat;
    longint avg;
    lat = longint'(n_lateral) * 256;
    if (!n_depth[0]) begin
      lat += longint'(even_offset);
    end
    avg = (n_hits != 0) ? sum_pos / longint'(n_hits) : 0;
    c.id = id_next;
    c.hits = n_hits;
    c.depth = n_depth;
    c.lateral = lat[LAT_W-1:0];
    c.mean = avg[POS_W-1:0];
    c.last_of_run = last_of_run;
    expected_clusters.insert(expected_clusters.size(), c);
    id_next = id_next + ID_W'(1);
  endfunction

  function automatic void take_hit(input logic [SEG_W-1:0] seg,
                                   input logic signed [POS_W-1:0] pos_in, input bit last);
    int delta;
    longint pos;
    pos = pos_in;
    if (!cl_open) begin
      open_cluster(seg, pos);
    end else begin
      delta = int'(seg) - int'(last_seg);
      if (delta == 1 || delta == 2) begin
        if (n_hits != CNT_W'(SEGMENT_COUNT)) n_hits++;
        if (delta == 1 && n_depth != CNT_W'(SEGMENT_COUNT)) n_depth++;
        if ((delta == 2 || (older_ok && int'(seg) - int'(older_seg) == 2)) &&
            n_lateral != CNT_W'(SEGMENT_COUNT)) begin
          n_lateral++;
        end
        sum_pos += pos;
        older_seg = last_seg;
        older_ok = 1'b1;
        last_seg = seg;
      end else begin
        emit_cluster(!last);
        open_cluster(seg, pos);
      end
    end
    if (last) begin
      emit_cluster(1'b1);
      cl_open = 1'b0;
      id_next = '0;
    end
  endfunction

  always @(posedge clk) begin
    cluster_t want;
    cluster_t got;
    if (rst) begin
      even_offset = '0;
      cl_open = 1'b0;
      id_next = '0;
      expected_clusters.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.id = m_tdata[9:0];
        got.hits = m_tdata[20:10];
        got.depth = m_tdata[31:21];
        got.lateral = m_tdata[51:32];
        got.mean = m_tdata[71:52];
        got.last_of_run = m_tlast;
        if (expected_clusters.size() == 0) begin
          report_mismatch($sformatf("unexpected cluster with id %0d", got.id));
        end else begin
          want = expected_clusters.pop_front();
          check_field("cluster_id", want.id, got.id, want.id);
          check_field("hit_count", want.id, got.hits, want.hits);
          check_field("depth_size", want.id, got.depth, want.depth);
          check_field("lateral_size", want.id, longint'($signed(got.lateral)),
                      longint'($signed(want.lateral)));
          check_field("mean_position", want.id, longint'($signed(got.mean)),
                      longint'($signed(want.mean)));
          check_field("last_of_run", want.id, got.last_of_run, want.last_of_run);
          done_cnt++;
        end
      end
      if (cfg_we) begin
        even_offset = cfg_wdata;
      end
      if (s_tvalid && s_tready) begin
        take_hit(s_tdata[SEG_W-1:0], s_tdata[SEG_W+POS_W-1:SEG_W], s_tlast);
      end
    end
    mismatches <= err_cnt;
    outstanding <= expected_clusters.size();
    clusters_checked <= done_cnt;
  end

endmodule

// File: tb/strip_hit_clusterer_tb.sv
`timescale 1ns / 1ps

module strip_hit_clusterer_tb;
  import shc_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int SETTLE_CYCLES = 100;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [OFS_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tlast;

  int mismatches;
  int outstanding;
  int clusters_checked;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_toggle = 1'b0;
  int hits_sent = 0;
  int layers_sent = 0;
  int offsets_used = 0;

  int d_seg[21] = '{0, 1023, 5, 6, 8, 9, 10, 20, 22, 30, 31, 32, 32, 31, 50, 60,
                    100, 101, 102, 200, 201};
  int d_pos[21] = '{-524288, 524287, 100, 200, -300, 7, 3, -5, -6, 1, -1, -2, 5, 4,
                    -7, 8, 1, 2, -3, -3, -4};
  bit d_last[21] = '{1, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0, 1};

  strip_hit_clusterer u_dut (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  strip_hit_clusterer_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .mismatches, .outstanding, .clusters_checked
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Run stopped after %0d cycles with %0d clusters outstanding.",
             LIMIT_CYCLES, outstanding);
    $display("FAILED: results differ");
    $finish;
  end

  // The output side either stalls at random or, on request, holds off for a long stretch.
  initial begin
    bit seen;
    int hold_left;
    seen = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_toggle != seen) begin
        seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic logic [POS_W-1:0] pick_position(input logic [POS_W-1:0] center);
    case ($urandom_range(7))
      0: return {1'b1, {(POS_W-1){1'b0}}};
      1: return {1'b0, {(POS_W-1){1'b1}}};
      2, 3: return POS_W'($urandom);
      default: return center + POS_W'($urandom_range(511)) - POS_W'(256);
    endcase
  endfunction

  task automatic send_hit(input logic [SEG_W-1:0] seg, input logic [POS_W-1:0] pos,
                          input bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_W-SEG_W-POS_W){1'b0}}, pos, seg};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    hits_sent++;
  endtask

  task automatic wait_all_clusters();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_offset(input int value);
    wait_all_clusters();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= OFS_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    offsets_used++;
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
  endtask

  // Mostly ascending runs of neighbors with occasional gaps, repeats and steps back;
  // a noisy layer uses random segments throughout.
  task automatic send_layer(input int length, input bit noisy);
    int seg;
    int nxt;
    int count;
    int r;
    int jump_pct;
    bit stop;
    logic [POS_W-1:0] center;
    seg = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(200);
    center = POS_W'($urandom);
    jump_pct = $urandom_range(40);
    count = 0;
    stop = 1'b0;
    while (!stop) begin
      r = $urandom_range(99);
      if (noisy) begin
        nxt = $urandom_range(1023);
      end else if (r < jump_pct) begin
        nxt = seg + int'($urandom_range(3, 40));
      end else if (r < jump_pct + 6) begin
        nxt = seg - int'($urandom_range(5));
      end else begin
        nxt = seg + int'($urandom_range(1, 2));
      end
      count++;
      stop = (count >= length) || nxt < 0 || nxt > SEGMENT_COUNT - 1;
      send_hit(SEG_W'(seg), pick_position(center), stop);
      seg = nxt;
    end
    layers_sent++;
  endtask

  task automatic run_random(input int items);
    int start;
    int len;
    start = hits_sent;
    while (hits_sent - start < items) begin
      case ($urandom_range(19))
        0: len = $urandom_range(61, 200);
        1, 2, 3: len = $urandom_range(13, 60);
        default: len = $urandom_range(1, 12);
      endcase
      send_layer(len, $urandom_range(6) == 0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_offset(-1024);
    for (int i = 0; i < 21; i++) begin
      send_hit(SEG_W'(d_seg[i]), POS_W'(d_pos[i]), d_last[i]);
    end
    layers_sent += 6;

    set_offset(1023);
    set_idling(0, 0);
    run_random(200);

    set_offset(-1);
    set_idling(57, 0);
    run_random(200);

    set_offset(1024);
    set_idling(0, 57);
    run_random(200);

    set_offset(0);
    set_idling(19, 19);
    run_random(200);

    // The output holds off while hits keep coming, so the block backs up into its input.
    set_offset(int'($urandom_range(2048)) - 1024);
    set_idling(0, 0);
    hold_toggle <= ~hold_toggle;
    run_random(80);
    wait_all_clusters();
    set_idling(19, 19);
    run_random(100);

    wait_all_clusters();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d hits in %0d layers under %0d offset settings; %0d clusters checked.",
             hits_sent, layers_sent, offsets_used, clusters_checked);
    $display("Covered all idling mixes and a %0d-cycle output hold-off that stalled the input.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/shc_pkg.sv
rtl/strip_hit_clusterer.sv
tb/strip_hit_clusterer_checker.sv
tb/strip_hit_clusterer_tb.sv
